// ===== hw/rtl/mpa_pkg.sv =====
// Shared types, codes and the channel mask decoder for the masked pixel
// to ARGB8888 converter. No dependencies.
`default_nettype none

package mpa_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PIXEL_SIZE = 3'd0;
    localparam logic [2:0] REG_RED_MASK   = 3'd1;
    localparam logic [2:0] REG_GREEN_MASK = 3'd2;
    localparam logic [2:0] REG_BLUE_MASK  = 3'd3;
    localparam logic [2:0] REG_ALPHA_MASK = 3'd4;

    // Input pixel width codes
    localparam logic [1:0] PIX_8  = 2'd0;
    localparam logic [1:0] PIX_16 = 2'd1;
    localparam logic [1:0] PIX_24 = 2'd2;
    localparam logic [1:0] PIX_32 = 2'd3;

    localparam int CHAN_BITS = 8;

    // Decoded channel mask: position of lowest set bit and run length (0..8)
    typedef struct packed {
        logic [4:0] shift;
        logic [3:0] run;
    } chan_cfg_t;

    // Reset decodes of the default masks
    localparam chan_cfg_t RED_RESET   = '{shift: 5'd16, run: 4'd8};
    localparam chan_cfg_t GREEN_RESET = '{shift: 5'd8,  run: 4'd8};
    localparam chan_cfg_t BLUE_RESET  = '{shift: 5'd0,  run: 4'd8};
    localparam chan_cfg_t ALPHA_RESET = '{shift: 5'd24, run: 4'd8};

    // Lowest set bit, then the first contiguous run capped at eight bits.
    // An all-zero mask decodes to a zero run.
    function automatic chan_cfg_t decode_mask(input logic [31:0] mask);
        chan_cfg_t   c;
        logic        found;
        logic        cont;
        logic [31:0] sh;
        c.shift = 5'd0;
        c.run   = 4'd0;
        found   = 1'b0;
        cont    = 1'b1;
        for (int i = 0; i < 32; i++) begin
            if (!found && mask[i]) begin
                c.shift = 5'(i);
                found   = 1'b1;
            end
        end
        sh = mask >> c.shift;
        for (int j = 0; j < CHAN_BITS; j++) begin
            if (cont && sh[j]) begin
                c.run = c.run + 4'd1;
            end else begin
                cont = 1'b0;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/masked_pixel_to_argb8888_core.sv =====
// Top level of the masked pixel to ARGB8888 converter: config registers,
// pixel width truncation, four channel extractors and the output register.
// Depends on mpa_pkg and mpa_chan_extract.
// An accepted input transaction shows its result on m_tvalid in the next cycle.
// Throughput: one pixel per clock; the single output register accepts a new
// pixel in the cycle its held result is taken.
// Masks are decoded as they are written, so the datapath is shift and mask only.
// Reset: output empty, registers at 32 bit pixel with the 0xAARRGGBB masks.
`default_nettype none

module masked_pixel_to_argb8888_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel_word
    input  wire logic        s_tlast,   // last_pixel
    // ARGB output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] argb_word
    output logic             m_tlast    // last_out
);

    logic [1:0]         pixel_size_reg;
    mpa_pkg::chan_cfg_t red_cfg_reg;
    mpa_pkg::chan_cfg_t green_cfg_reg;
    mpa_pkg::chan_cfg_t blue_cfg_reg;
    mpa_pkg::chan_cfg_t alpha_cfg_reg;
    logic               alpha_zero_reg;
    mpa_pkg::chan_cfg_t wdata_cfg;

    logic [31:0] pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha_raw;
    logic [7:0]  alpha;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic        out_last_reg;
    logic        in_fire;

    // Config writes, masks decoded on the way in
    assign wdata_cfg = mpa_pkg::decode_mask(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_size_reg <= mpa_pkg::PIX_32;
            red_cfg_reg    <= mpa_pkg::RED_RESET;
            green_cfg_reg  <= mpa_pkg::GREEN_RESET;
            blue_cfg_reg   <= mpa_pkg::BLUE_RESET;
            alpha_cfg_reg  <= mpa_pkg::ALPHA_RESET;
            alpha_zero_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mpa_pkg::REG_PIXEL_SIZE: pixel_size_reg <= cfg_wdata[1:0];
                mpa_pkg::REG_RED_MASK:   red_cfg_reg    <= wdata_cfg;
                mpa_pkg::REG_GREEN_MASK: green_cfg_reg  <= wdata_cfg;
                mpa_pkg::REG_BLUE_MASK:  blue_cfg_reg   <= wdata_cfg;
                mpa_pkg::REG_ALPHA_MASK:
                begin
                    alpha_cfg_reg  <= wdata_cfg;
                    alpha_zero_reg <= (cfg_wdata == 32'd0);
                end
                default: ;
            endcase
        end
    end

    // Truncate the pixel to its configured width
    always_comb
    begin
        case (pixel_size_reg)
            mpa_pkg::PIX_8:  pixel = {24'd0, s_tdata[7:0]};
            mpa_pkg::PIX_16: pixel = {16'd0, s_tdata[15:0]};
            mpa_pkg::PIX_24: pixel = {8'd0, s_tdata[23:0]};
            default:         pixel = s_tdata;
        endcase
    end

    mpa_chan_extract u_red   (.pixel(pixel), .cfg(red_cfg_reg),   .chan(red));
    mpa_chan_extract u_green (.pixel(pixel), .cfg(green_cfg_reg), .chan(green));
    mpa_chan_extract u_blue  (.pixel(pixel), .cfg(blue_cfg_reg),  .chan(blue));
    mpa_chan_extract u_alpha (.pixel(pixel), .cfg(alpha_cfg_reg), .chan(alpha_raw));

    // zero alpha mask means opaque
    assign alpha = alpha_zero_reg ? 8'hFF : alpha_raw;

    // Output register; refills in the same cycle it drains
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {alpha, red, green, blue};
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_tvalid)
        else $error("accepted pixel did not reach the output register");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !in_fire) |=> !m_tvalid)
        else $error("result delivered but output still valid");

    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        (red_cfg_reg.run <= 4'd8) && (green_cfg_reg.run <= 4'd8) &&
        (blue_cfg_reg.run <= 4'd8) && (alpha_cfg_reg.run <= 4'd8))
        else $error("decoded channel run exceeds eight bits");

    a_wr_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_addr == mpa_pkg::REG_ALPHA_MASK && cfg_wdata == 32'd0)
        |=> (alpha_zero_reg && alpha_cfg_reg.run == 4'd0))
        else $error("zero alpha mask not decoded as opaque");

endmodule

`default_nettype wire

// ===== hw/rtl/mpa_chan_extract.sv =====
// One channel extractor: shift, mask to the run, left-align in a byte.
// Depends on mpa_pkg for the decoded channel type.
`default_nettype none

module mpa_chan_extract (
    input  wire logic [31:0]       pixel,
    input  wire mpa_pkg::chan_cfg_t cfg,
    output logic [7:0]             chan
);

    logic [31:0] field;
    logic [8:0]  ones;
    logic [3:0]  loss;
    logic [7:0]  kept;

    // Field bits down to bit 0, keep the run, move it to the top of the byte
    always_comb
    begin
        field = pixel >> cfg.shift;
        ones  = (9'd1 << cfg.run) - 9'd1;
        loss  = 4'd8 - cfg.run;
        kept  = field[7:0] & ones[7:0];
        chan  = kept << loss;
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for masked_pixel_to_argb8888_core: drives pixel streams under
// several mask settings and checks each ARGB8888 transaction against a local predictor.
// Depends on mpa_pkg and the converter RTL.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 250;
    localparam int PHASE_PIXELS = 50;
    localparam int RAND_PHASES  = 8;

    typedef struct {
        logic [31:0] argb;
        logic        last;
    } argb_item_t;

    // Holds the converter settings, predicts each pixel and checks results in order
    class argb_scoreboard;
        logic [1:0]  pixel_size;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [31:0] alpha_mask;
        argb_item_t  expected_argb[$];
        int          errors;

        function new();
            pixel_size = mpa_pkg::PIX_32;
            red_mask   = 32'h00FF0000;
            green_mask = 32'h0000FF00;
            blue_mask  = 32'h000000FF;
            alpha_mask = 32'hFF000000;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                mpa_pkg::REG_PIXEL_SIZE: pixel_size = val[1:0];
                mpa_pkg::REG_RED_MASK:   red_mask   = val;
                mpa_pkg::REG_GREEN_MASK: green_mask = val;
                mpa_pkg::REG_BLUE_MASK:  blue_mask  = val;
                mpa_pkg::REG_ALPHA_MASK: alpha_mask = val;
                default: ;
            endcase
        endfunction

        // One channel: lowest set bit, first run capped at 8, left-aligned in a byte
        function logic [7:0] extract_channel(logic [31:0] pix, logic [31:0] mask);
            int unsigned sh;
            int unsigned rn;
            logic [31:0] field;
            if (mask == 32'd0)
                return 8'd0;
            sh = 0;
            while (sh < 31 && !mask[sh])
                sh++;
            rn = 0;
            while (rn < 8 && sh + rn < 32 && mask[sh + rn])
                rn++;
            field = (pix >> sh) & ((32'd1 << rn) - 32'd1);
            return 8'(field << (8 - rn));
        endfunction

        function logic [31:0] convert_pixel(logic [31:0] raw);
            logic [31:0] pix;
            logic [7:0]  a;
            pix = raw;
            case (pixel_size)
                mpa_pkg::PIX_8:  pix = raw & 32'h000000FF;
                mpa_pkg::PIX_16: pix = raw & 32'h0000FFFF;
                mpa_pkg::PIX_24: pix = raw & 32'h00FFFFFF;
                default:         pix = raw;
            endcase
            a = (alpha_mask == 32'd0) ? 8'hFF : extract_channel(pix, alpha_mask);
            return {a, extract_channel(pix, red_mask), extract_channel(pix, green_mask),
                    extract_channel(pix, blue_mask)};
        endfunction

        function void note_pixel(logic [31:0] raw, logic last);
            argb_item_t item;
            item.argb = convert_pixel(raw);
            item.last = last;
            expected_argb.push_back(item);
        endfunction

        task report(string what, logic [31:0] exp_val, logic [31:0] got_val);
            $display("mismatch %s: expected %08h got %08h", what, exp_val, got_val);
            errors++;
        endtask

        task check_result(logic [31:0] argb, logic last);
            argb_item_t item;
            if (expected_argb.size() == 0) begin
                report("unexpected transaction", 32'd0, argb);
            end else begin
                item = expected_argb.pop_front();
                if (argb !== item.argb)
                    report("argb_word", item.argb, argb);
                if (last !== item.last)
                    report("last_out", {31'd0, item.last}, {31'd0, last});
            end
        endtask

        function int pending();
            return expected_argb.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    argb_scoreboard argb_sb;
    bit             tx_no_idle;
    bit             rx_no_idle;
    int             stall_requests;
    int             cycle_count;

    masked_pixel_to_argb8888_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random backpressure, plus long hold-offs on request
    initial
    begin
        int stalls_done;
        int hold_left;
        stalls_done = 0;
        hold_left   = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && stalls_done != stall_requests)
            begin
                stalls_done++;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_no_idle)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 36);
        end
    end

    // Monitor: note accepted pixels, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                argb_sb.note_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                argb_sb.check_result(m_tdata, m_tlast);
        end
    end

    // One pixel transaction, with a random gap in front of it unless tx_no_idle is set
    task automatic send_pixel(input logic [31:0] pix, input logic last);
        if (!tx_no_idle)
        begin
            while ($urandom_range(99) < 36)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result is out and the pipe is empty
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (argb_sb.pending() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the registers selected in sel; only called while idle
    task automatic apply_config(input logic [4:0] sel, input logic [1:0] ps,
                                input logic [31:0] rm, input logic [31:0] gm,
                                input logic [31:0] bm, input logic [31:0] am);
        logic [31:0] vals[5];
        logic [2:0]  idx[5];
        vals[0] = {30'd0, ps};
        vals[1] = rm;
        vals[2] = gm;
        vals[3] = bm;
        vals[4] = am;
        idx[0]  = mpa_pkg::REG_PIXEL_SIZE;
        idx[1]  = mpa_pkg::REG_RED_MASK;
        idx[2]  = mpa_pkg::REG_GREEN_MASK;
        idx[3]  = mpa_pkg::REG_BLUE_MASK;
        idx[4]  = mpa_pkg::REG_ALPHA_MASK;
        for (int i = 0; i < 5; i++)
        begin
            if (sel[i])
            begin
                cfg_we    <= 1'b1;
                cfg_addr  <= idx[i];
                cfg_wdata <= vals[i];
                @(posedge clk);
                argb_sb.set_reg(idx[i], vals[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Mix of zero, full, random and run-shaped masks, some split
    function automatic logic [31:0] random_mask();
        logic [63:0] m;
        int unsigned sh;
        int unsigned rn;
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default:
            begin
                sh = $urandom_range(31);
                rn = $urandom_range(12, 1);
                m  = ((64'd1 << rn) - 64'd1) << sh;
                if ($urandom_range(3) == 0)
                    m = m | ({32'd0, $urandom} << (sh + rn + 1));
                return m[31:0];
            end
        endcase
    endfunction

    // Stimulus
    initial
    begin
        argb_sb        = new();
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        stall_requests = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= mpa_pkg::REG_PIXEL_SIZE;
        cfg_wdata <= 32'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        s_tlast   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: plain 32 bit ARGB
        send_pixel(32'h00000000, 1'b0);
        send_pixel(32'hFFFFFFFF, 1'b1);
        send_pixel(32'h12345678, 1'b0);
        send_pixel(32'h80000001, 1'b1);
        drain();

        // Zero red mask, wide green run, split blue mask, opaque alpha
        apply_config(5'b11111, mpa_pkg::PIX_32, 32'h0, 32'h000FFF00, 32'h00000F0F, 32'h0);
        send_pixel(32'hFFFFFFFF, 1'b0);
        send_pixel(32'hA5A5A5A5, 1'b1);
        send_pixel(32'h00000000, 1'b0);
        drain();

        // 8 bit pixel, short channels, alpha above the pixel width
        apply_config(5'b11111, mpa_pkg::PIX_8, 32'h000000E0, 32'h0000001C, 32'h00000003,
                     32'h0000FF00);
        send_pixel(32'h000000FF, 1'b0);
        send_pixel(32'h0000006D, 1'b1);
        send_pixel(32'hFFFFFF00, 1'b0);
        drain();

        // 16 bit RGB565 with alpha outside the pixel
        apply_config(5'b11111, mpa_pkg::PIX_16, 32'h0000F800, 32'h000007E0, 32'h0000001F,
                     32'hFFFF0000);
        send_pixel(32'h0000FFFF, 1'b1);
        send_pixel(32'h1234ABCD, 1'b0);
        drain();

        // 24 bit pixel, full mask, top-bit mask, mask just above 24 bits
        apply_config(5'b11111, mpa_pkg::PIX_24, 32'hFFFFFFFF, 32'h80000000, 32'h00800000,
                     32'h01000000);
        send_pixel(32'hFFFFFFFF, 1'b0);
        send_pixel(32'h00FFFFFF, 1'b1);
        send_pixel(32'h7F000000, 1'b0);
        drain();

        // Random settings and pixels
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            apply_config({$urandom_range(3) != 0, $urandom_range(3) != 0,
                          $urandom_range(3) != 0, $urandom_range(3) != 0, 1'b1},
                         2'($urandom_range(3)), random_mask(), random_mask(),
                         random_mask(), random_mask());
            tx_no_idle = (ph == 3);
            rx_no_idle = (ph == 3);
            if (ph == 5)
                stall_requests++;
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel($urandom, ($urandom_range(15) == 0));
            drain();
        end

        // Final sweep back to 8 bit with full masks
        apply_config(5'b11111, mpa_pkg::PIX_8, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                     32'hFFFFFFFF);
        for (int i = 0; i < 10; i++)
            send_pixel($urandom, ($urandom_range(1) == 0));
        drain();
        repeat (10) @(posedge clk);

        if (argb_sb.errors == 0 && argb_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
